// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL of the ordered list block.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OAID_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define OAID_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");
`else
`define OAID_ASSERT(lbl, clk, rstn, prop)
`define OAID_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// ----- hw/rtl/oaid_pkg.sv -----
// Types and constants for the ordered list block.
// No dependencies; used by the cell, the interfaces and the top level.
package oaid_pkg;

  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned WORD_BITS_DEF = 32;
  // Width of a cell target index; covers indices 0 to 2047.
  localparam int unsigned POS_MAX_W     = 11;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [MODE_W-1:0] {
    M_APPEND = 3'd0,
    M_INSERT = 3'd1,
    M_EDIT   = 3'd2,
    M_DELETE = 3'd3,
    M_READ   = 3'd4,
    M_FIND   = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_WRITE  = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_DELETE = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e               op;
    logic [POS_MAX_W-1:0]   target;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/oaid_in_if.sv -----
// Request channel of the ordered list block: valid/ready plus one request word.
// Depends on oaid_pkg.
interface oaid_in_if;
  logic                             valid;
  logic                             ready;
  logic [oaid_pkg::MODE_W-1:0]      mode;
  logic [oaid_pkg::POS_W-1:0]       position;
  logic signed [oaid_pkg::VALUE_W-1:0] value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

// ----- hw/rtl/oaid_out_if.sv -----
// Result channel of the ordered list block: valid/ready plus one result word.
// Depends on oaid_pkg.
interface oaid_out_if;
  logic                                valid;
  logic                                ready;
  logic [oaid_pkg::STATUS_W-1:0]       status;
  logic signed [oaid_pkg::VALUE_W-1:0] read_value;
  logic signed [oaid_pkg::POS_W-1:0]   found_position;
  logic [oaid_pkg::POS_W-1:0]          entry_count;

  modport source (output valid, status, read_value, found_position, entry_count,
                  input ready);
  modport sink   (input valid, status, read_value, found_position, entry_count,
                  output ready);
endinterface

// ----- hw/rtl/ordered_array_insert_delete.sv -----
// Ordered list of up to CAPACITY words with a fill count, kept in a row of cells.
// Requests enter on in_i (mode, position, value), one result per request leaves
// on out_o (status, read_value, found_position, entry_count). Both channels move
// a word when valid and ready are high at a rising clk_i edge.
// Append, insert, edit, delete and read act on the cells in the cycle the
// request is accepted; the result is registered and valid in the next cycle.
// Inserts and deletes shift all later cells by one place in that same cycle.
// Find goes through an extra state: the cells compare in parallel, the match bits are
// registered, and a priority encoder picks the lowest index in the next cycle.
// One request is in flight at a time, so the rate is one request every cycle
// when the result is taken at once; a find holds off the next request until
// its result is loaded into the output register.
// If out_o is stalled, the result stays in the output register and the next
// request is taken in the cycle the result drains.
// rst_ni (asynchronous, active low) empties the list and drops any pending
// result; entry contents are not cleared and are never read before written.
module ordered_array_insert_delete #(
  parameter int unsigned CAPACITY  = oaid_pkg::CAPACITY_DEF,
  parameter int unsigned WORD_BITS = oaid_pkg::WORD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  oaid_in_if.sink    in_i,
  oaid_out_if.source out_o
);
  `include "assert_macros.svh"

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CMP_W = (CNT_W > oaid_pkg::POS_W) ? CNT_W : oaid_pkg::POS_W;
  localparam int unsigned PW    = oaid_pkg::POS_MAX_W;
  // Only the first 32 cells can be addressed by a 5-bit position.
  localparam int unsigned RD_N  = (CAPACITY < 32) ? CAPACITY : 32;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_FIND = 1'b1;

  logic state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic out_valid_q;
  logic [oaid_pkg::STATUS_W-1:0] status_q, status_d;
  logic [oaid_pkg::VALUE_W-1:0]  rd_q, rd_d;
  logic [oaid_pkg::POS_W-1:0]    found_q, found_d;
  logic out_load;

  logic accept;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]  cell_eq;
  logic [CAPACITY-1:0]  match_q;
  oaid_pkg::cell_ctl_t  ctl;

  logic [CMP_W-1:0] pos_c, cnt_c;
  logic [oaid_pkg::STATUS_W-1:0] chk;
  logic [WORD_BITS-1:0] rd_sel;
  logic             hit;
  logic [IDX_W-1:0] fidx;

  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;
  assign word       = WORD_BITS'(in_i.value);
  assign pos_c      = CMP_W'(in_i.position);
  assign cnt_c      = CMP_W'(count_q);

  // Index check shared by edit, delete and read.
  always_comb begin
    if (count_q == '0) begin
      chk = oaid_pkg::ST_EMPTY;
    end else if (pos_c >= cnt_c) begin
      chk = oaid_pkg::ST_BAD_INDEX;
    end else begin
      chk = oaid_pkg::ST_OK;
    end
  end

  always_comb begin
    rd_sel = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (in_i.position == oaid_pkg::POS_W'(k)) rd_sel = cell_data[k];
    end
  end

  always_comb begin
    hit  = 1'b0;
    fidx = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (match_q[k]) begin
        hit  = 1'b1;
        fidx = IDX_W'(k);
      end
    end
  end

  always_comb begin
    ctl.op     = oaid_pkg::CELL_HOLD;
    ctl.target = PW'(in_i.position);
    count_d    = count_q;
    state_d    = state_q;
    status_d   = oaid_pkg::ST_OK;
    rd_d       = '0;
    found_d    = '1;
    out_load   = 1'b0;
    if (state_q == S_FIND) begin
      state_d  = S_IDLE;
      out_load = 1'b1;
      if (hit) begin
        found_d = oaid_pkg::POS_W'(fidx);
      end else begin
        status_d = oaid_pkg::ST_NOT_FOUND;
      end
    end else if (accept) begin
      out_load = 1'b1;
      case (in_i.mode)
        oaid_pkg::M_APPEND: begin
          if (count_q >= CNT_W'(CAPACITY)) begin
            status_d = oaid_pkg::ST_FULL;
          end else begin
            ctl.op     = oaid_pkg::CELL_WRITE;
            ctl.target = PW'(count_q);
            count_d    = count_q + 1'b1;
          end
        end
        oaid_pkg::M_INSERT: begin
          if (pos_c > cnt_c) begin
            status_d = oaid_pkg::ST_BAD_INDEX;
          end else if (count_q >= CNT_W'(CAPACITY)) begin
            status_d = oaid_pkg::ST_FULL;
          end else begin
            ctl.op  = oaid_pkg::CELL_INSERT;
            count_d = count_q + 1'b1;
          end
        end
        oaid_pkg::M_EDIT: begin
          status_d = chk;
          if (chk == oaid_pkg::ST_OK) ctl.op = oaid_pkg::CELL_WRITE;
        end
        oaid_pkg::M_DELETE: begin
          status_d = chk;
          if (chk == oaid_pkg::ST_OK) begin
            ctl.op  = oaid_pkg::CELL_DELETE;
            count_d = count_q - 1'b1;
          end
        end
        oaid_pkg::M_READ: begin
          status_d = chk;
          rd_d     = (chk == oaid_pkg::ST_OK) ? oaid_pkg::VALUE_W'(rd_sel) : '1;
        end
        oaid_pkg::M_FIND: begin
          out_load = 1'b0;
          state_d  = S_FIND;
        end
        default: status_d = oaid_pkg::ST_BAD_INDEX;
      endcase
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_BITS-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end

    oaid_cell #(
      .WORD_BITS(WORD_BITS),
      .INDEX    (g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .word_i (word),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[g]),
      .eq_o   (cell_eq[g])
    );

    // Match bits latched on a find; only live entries count.
    always_ff @(posedge clk_i) begin
      if (accept && (in_i.mode == oaid_pkg::M_FIND)) begin
        match_q[g] <= cell_eq[g] && (CNT_W'(g) < count_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= status_d;
      rd_q     <= rd_d;
      found_q  <= found_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = status_q;
  assign out_o.read_value     = rd_q;
  assign out_o.found_position = found_q;
  assign out_o.entry_count    = oaid_pkg::POS_W'(count_q);

  `OAID_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY))
  `OAID_ASSERT(a_find_one_cycle, clk_i, rst_ni, (state_q == S_FIND) |=> (state_q == S_IDLE))
  `OAID_NEVER(a_find_slot_busy, clk_i, rst_ni, (state_q == S_FIND) && out_valid_q)
  `OAID_ASSERT(a_result_follows, clk_i, rst_ni,
    (accept && (in_i.mode != oaid_pkg::M_FIND)) |=> out_valid_q)
  `OAID_ASSERT(a_count_step, clk_i, rst_ni,
    !accept |=> (count_q == $past(count_q)))

endmodule

// ----- hw/rtl/oaid_cell.sv -----
// One storage cell of the list: holds one entry, takes a neighbor's entry on shifts.
// Depends on oaid_pkg.
module oaid_cell #(
  parameter int unsigned WORD_BITS = oaid_pkg::WORD_BITS_DEF,
  parameter int unsigned INDEX     = 0
) (
  input  logic                    clk_i,
  input  oaid_pkg::cell_ctl_t     ctl_i,
  input  logic [WORD_BITS-1:0]    word_i,
  input  logic [WORD_BITS-1:0]    left_i,
  input  logic [WORD_BITS-1:0]    right_i,
  output logic [WORD_BITS-1:0]    data_o,
  output logic                    eq_o
);

  localparam int unsigned PW = oaid_pkg::POS_MAX_W;
  localparam logic [PW-1:0] Idx = PW'(INDEX);

  logic [WORD_BITS-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      oaid_pkg::CELL_HOLD: data_d = data_q;
      oaid_pkg::CELL_WRITE: begin
        if (Idx == ctl_i.target) data_d = word_i;
      end
      oaid_pkg::CELL_INSERT: begin
        if (Idx == ctl_i.target) begin
          data_d = word_i;
        end else if (Idx > ctl_i.target) begin
          data_d = left_i;
        end
      end
      oaid_pkg::CELL_DELETE: begin
        if (Idx >= ctl_i.target) data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign eq_o   = (data_q == word_i);

endmodule

// ----- sim/ordered_array_insert_delete_test.sv -----
// Self-checking testbench for ordered_array_insert_delete: a directed table, then phased random
// requests, each result checked against its table answer or a list model kept in this file.
// Depends on oaid_pkg, oaid_in_if, oaid_out_if and the RTL top level.
module ordered_array_insert_delete_test;
  timeunit 1ns;
  timeprecision 1ps;

  import oaid_pkg::*;

  localparam int unsigned DEPTH = CAPACITY_DEF;
  localparam logic [MODE_W-1:0] M_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] M_SPARE7 = 3'd7;
  localparam logic [POS_W-1:0] NO_POSITION = '1;
  localparam logic [VALUE_W-1:0] FAILED_READ = '1;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASE_LEN = 100;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic [POS_W-1:0]    found_position;
    logic [POS_W-1:0]    entry_count;
  } reply_t;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
    int                 reps;
    bit                 typed;
    reply_t             want;
  } plan_row_t;

  localparam reply_t ANY = '0;

  // Hand-checked rows carry their answer; the rest go through the list model.
  plan_row_t plan [26] = '{
    '{M_READ,   5'd0,  32'd0,          1,  1'b1, '{ST_EMPTY, FAILED_READ, NO_POSITION, 5'd0}},
    '{M_DELETE, 5'd0,  32'd0,          1,  1'b1, '{ST_EMPTY, 32'd0, NO_POSITION, 5'd0}},
    '{M_EDIT,   5'd0,  32'd5,          1,  1'b1, '{ST_EMPTY, 32'd0, NO_POSITION, 5'd0}},
    '{M_FIND,   5'd0,  32'd0,          1,  1'b1, '{ST_NOT_FOUND, 32'd0, NO_POSITION, 5'd0}},
    '{M_INSERT, 5'd1,  32'd9,          1,  1'b1, '{ST_BAD_INDEX, 32'd0, NO_POSITION, 5'd0}},
    '{M_SPARE6, 5'd0,  32'd0,          1,  1'b1, '{ST_BAD_INDEX, 32'd0, NO_POSITION, 5'd0}},
    '{M_SPARE7, 5'd31, 32'hFFFFFFFF,   1,  1'b1, '{ST_BAD_INDEX, 32'd0, NO_POSITION, 5'd0}},
    '{M_APPEND, 5'd0,  32'h7FFFFFFF,   1,  1'b1, '{ST_OK, 32'd0, NO_POSITION, 5'd1}},
    '{M_INSERT, 5'd0,  32'h80000000,   1,  1'b1, '{ST_OK, 32'd0, NO_POSITION, 5'd2}},
    '{M_INSERT, 5'd2,  32'd0,          1,  1'b1, '{ST_OK, 32'd0, NO_POSITION, 5'd3}},
    '{M_READ,   5'd0,  32'd0,          1,  1'b0, ANY},
    '{M_READ,   5'd3,  32'd0,          1,  1'b1, '{ST_BAD_INDEX, FAILED_READ, NO_POSITION, 5'd3}},
    '{M_EDIT,   5'd1,  32'hFFFFFFFF,   1,  1'b1, '{ST_OK, 32'd0, NO_POSITION, 5'd3}},
    '{M_FIND,   5'd0,  32'hFFFFFFFF,   1,  1'b0, ANY},
    '{M_FIND,   5'd0,  32'd12345,      1,  1'b1, '{ST_NOT_FOUND, 32'd0, NO_POSITION, 5'd3}},
    '{M_DELETE, 5'd0,  32'd0,          1,  1'b1, '{ST_OK, 32'd0, NO_POSITION, 5'd2}},
    '{M_DELETE, 5'd31, 32'd0,          1,  1'b1, '{ST_BAD_INDEX, 32'd0, NO_POSITION, 5'd2}},
    '{M_EDIT,   5'd2,  32'd7,          1,  1'b1, '{ST_BAD_INDEX, 32'd0, NO_POSITION, 5'd2}},
    '{M_APPEND, 5'd0,  32'd5,          14, 1'b0, ANY},
    '{M_APPEND, 5'd0,  32'd6,          1,  1'b1, '{ST_FULL, 32'd0, NO_POSITION, 5'd16}},
    '{M_INSERT, 5'd16, 32'd6,          1,  1'b1, '{ST_FULL, 32'd0, NO_POSITION, 5'd16}},
    '{M_INSERT, 5'd17, 32'd6,          1,  1'b1, '{ST_BAD_INDEX, 32'd0, NO_POSITION, 5'd16}},
    '{M_READ,   5'd15, 32'd0,          1,  1'b0, ANY},
    '{M_READ,   5'd16, 32'd0,          1,  1'b1, '{ST_BAD_INDEX, FAILED_READ, NO_POSITION, 5'd16}},
    '{M_FIND,   5'd0,  32'd5,          1,  1'b0, ANY},
    '{M_DELETE, 5'd15, 32'd0,          1,  1'b0, ANY}
  };

  localparam logic [MODE_W-1:0] MODE_OF [7] =
    '{M_APPEND, M_INSERT, M_EDIT, M_DELETE, M_READ, M_FIND, M_SPARE6};
  localparam logic [VALUE_W-1:0] VALUE_POOL [6] =
    '{32'd0, 32'd1, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h00C0FFEE};

  logic clk = 1'b0;
  logic rst_n;

  oaid_in_if  req_if ();
  oaid_out_if rsp_if ();

  ordered_array_insert_delete dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  always #1 clk = ~clk;

  // list model
  logic [VALUE_W-1:0] shadow_words [DEPTH];
  int                 shadow_count = 0;

  reply_t pending_results [$];
  bit     row_typed = 1'b0;
  reply_t row_want  = '0;
  bit     steady    = 1'b0;
  int     idle_cycles = 0;
  int     mismatches = 0;
  int     results_seen = 0;
  int     mode_hits [8];
  int     full_hits = 0;
  int     absent_hits = 0;
  int     reject_hits = 0;

  function automatic reply_t list_apply(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                                        logic [VALUE_W-1:0] word);
    reply_t res;
    res = '{ST_OK, '0, NO_POSITION, '0};
    case (mode)
      M_APPEND: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_words[shadow_count] = word;
          shadow_count++;
        end
      end
      M_INSERT: begin
        if (pos > shadow_count) begin
          res.status = ST_BAD_INDEX;
        end else if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > pos; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[pos] = word;
          shadow_count++;
        end
      end
      M_EDIT, M_DELETE, M_READ: begin
        if (shadow_count == 0) res.status = ST_EMPTY;
        else if (pos >= shadow_count) res.status = ST_BAD_INDEX;
        if (mode == M_READ) begin
          res.read_value = (res.status == ST_OK) ? shadow_words[pos] : FAILED_READ;
        end else if (res.status == ST_OK && mode == M_EDIT) begin
          shadow_words[pos] = word;
        end else if (res.status == ST_OK) begin
          for (int i = pos; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count--;
        end
      end
      M_FIND: begin
        res.status = ST_NOT_FOUND;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_words[i] == word) begin
            res.status = ST_OK;
            res.found_position = i[POS_W-1:0];
            break;
          end
        end
      end
      default: res.status = ST_BAD_INDEX;
    endcase
    res.entry_count = shadow_count[POS_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Check finished words first, then queue the answer for the word taken this edge.
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{rsp_if.status, rsp_if.read_value, rsp_if.found_position, rsp_if.entry_count};
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result #%0d with nothing expected", results_seen));
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("result #%0d status %0d, expected %0d",
                                      results_seen, got.status, want.status));
          if (got.read_value !== want.read_value)
            report_mismatch($sformatf("result #%0d read_value %h, expected %h",
                                      results_seen, got.read_value, want.read_value));
          if (got.found_position !== want.found_position)
            report_mismatch($sformatf("result #%0d found_position %h, expected %h",
                                      results_seen, got.found_position, want.found_position));
          if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("result #%0d entry_count %0d, expected %0d",
                                      results_seen, got.entry_count, want.entry_count));
        end
      end
      if (req_if.valid && req_if.ready) begin
        want = list_apply(req_if.mode, req_if.position, req_if.value);
        mode_hits[req_if.mode]++;
        if (want.status == ST_FULL) full_hits++;
        if (want.status == ST_NOT_FOUND) absent_hits++;
        if (want.status == ST_BAD_INDEX || want.status == ST_EMPTY) reject_hits++;
        pending_results.push_back(row_typed ? row_want : want);
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(int kind);
    int weights [7];
    int r;
    int acc;
    case (kind)
      0: weights = '{30, 30, 8, 5, 10, 12, 5};    // grow toward full
      1: weights = '{5, 5, 10, 40, 15, 20, 5};    // shrink toward empty
      default: weights = '{15, 15, 15, 15, 18, 18, 4};
    endcase
    r = $urandom_range(0, 99);
    acc = 0;
    for (int i = 0; i < 7; i++) begin
      acc += weights[i];
      if (r < acc) begin
        if (i == 6 && $urandom_range(0, 1)) return M_SPARE7;
        return MODE_OF[i];
      end
    end
    return M_READ;
  endfunction

  function automatic logic [POS_W-1:0] pick_position(logic [MODE_W-1:0] mode);
    int top;
    int r;
    top = (mode == M_INSERT) ? shadow_count : shadow_count - 1;
    r = $urandom_range(0, 99);
    if (r < 75 && top >= 0) return POS_W'($urandom_range(0, top));
    if (r < 90)
      return POS_W'(shadow_count + ((mode == M_INSERT) ? $urandom_range(0, 1) : 0));
    return POS_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(logic [MODE_W-1:0] mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == M_FIND && shadow_count > 0 && r < 50)
      return shadow_words[$urandom_range(0, shadow_count - 1)];
    if (r < 70) return VALUE_POOL[$urandom_range(0, 5)];
    return $urandom();
  endfunction

  // Called at a falling edge; holds valid until the word is taken.
  task automatic send_request(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                              logic [VALUE_W-1:0] value, bit typed, reply_t want);
    req_if.mode     = mode;
    req_if.position = pos;
    req_if.value    = value;
    row_typed       = typed;
    row_want        = want;
    req_if.valid    = 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // Steps to the next falling edge, idling and optionally waiting for all answers.
  task automatic hold_off(int cycles, bit drain);
    @(negedge clk);
    if (cycles > 0 || drain) begin
      req_if.valid = 1'b0;
      repeat (cycles) @(negedge clk);
      while (drain && pending_results.size() != 0) @(negedge clk);
    end
  endtask

  // result side: random stalls, none during steady stretches
  initial begin
    int stall;
    stall = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        rsp_if.ready = 1'b0;
        stall--;
      end else begin
        rsp_if.ready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(negedge clk);
    $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
    $display("ordered_array_insert_delete verification failed");
    $finish;
  end

  initial begin
    logic [MODE_W-1:0]  mode;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
    int                 kind;
    rst_n           = 1'b0;
    req_if.valid    = 1'b0;
    req_if.mode     = '0;
    req_if.position = '0;
    req_if.value    = '0;
    foreach (mode_hits[i]) mode_hits[i] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[k]) begin
      repeat (plan[k].reps) begin
        hold_off(pick_gap(), 1'b0);
        send_request(plan[k].mode, plan[k].position, plan[k].value, plan[k].typed,
                     plan[k].want);
      end
    end

    kind = 2;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        hold_off(1, 1'b1);
        kind = $urandom_range(0, 2);
        steady = ($urandom_range(0, 4) == 0);
      end else begin
        hold_off(pick_gap(), 1'b0);
      end
      mode  = pick_mode(kind);
      pos   = pick_position(mode);
      value = pick_value(mode);
      send_request(mode, pos, value, 1'b0, ANY);
    end

    steady = 1'b0;
    hold_off(0, 1'b1);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Requests: %0d append, %0d insert, %0d edit, %0d delete, %0d read, %0d find,",
             mode_hits[M_APPEND], mode_hits[M_INSERT], mode_hits[M_EDIT], mode_hits[M_DELETE],
             mode_hits[M_READ], mode_hits[M_FIND]);
    $display("  %0d unused; results checked: %0d (%0d full, %0d not found, %0d rejected), %0d errors",
             mode_hits[M_SPARE6] + mode_hits[M_SPARE7], results_seen, full_hits, absent_hits,
             reject_hits, mismatches);
    if (mismatches == 0) begin
      $display("ordered_array_insert_delete verification clean");
    end else begin
      $display("ordered_array_insert_delete verification failed");
    end
    $finish;
  end

endmodule
